@@ rtl/gpp_pkg.sv @@
// shared constants, types and helpers for the genotype pair probability block
package gpp_pkg;

  localparam int MAX_ALLELES    = 32;
  localparam int FREQ_FRAC_BITS = 16;

  localparam int IDX_W   = $clog2(MAX_ALLELES);
  localparam int COUNT_W = $clog2(MAX_ALLELES + 1);
  localparam int FREQ_W  = FREQ_FRAC_BITS + 1;
  localparam int TRANS_W = FREQ_W + 1;
  localparam int OUT_W   = 32;
  localparam int OUT_FRAC_BITS = 30;

  // product widths along the datapath
  localparam int G_W    = 2 * FREQ_W;
  localparam int KG_W   = FREQ_W + G_W;
  localparam int G2LO_W = FREQ_W;
  localparam int G2HI_W = G_W - FREQ_W;
  localparam int PLO_W  = KG_W + G2LO_W;
  localparam int PHI_W  = KG_W + G2HI_W;
  localparam int PT_W   = KG_W + TRANS_W;
  localparam int ACC_W  = 5 * FREQ_FRAC_BITS + 5;

  // alignment to 5*FREQ_FRAC_BITS fraction bits
  localparam int TRANS_SHIFT = FREQ_FRAC_BITS - 1;
  localparam int SAME_SHIFT  = 2 * FREQ_FRAC_BITS;
  localparam int ROUND_SHIFT = 5 * FREQ_FRAC_BITS - OUT_FRAC_BITS;
  localparam int RES_W       = ACC_W - ROUND_SHIFT;

  localparam logic [FREQ_W-1:0] ONE_Q = FREQ_W'(1) << FREQ_FRAC_BITS;
  localparam logic [ACC_W-1:0]  HALF  = ACC_W'(1) << (ROUND_SHIFT - 1);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = FREQ_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ALLELES_IN_USE = 2'd0,
    REG_KAPPA_NONE     = 2'd1,
    REG_KAPPA_ONE      = 2'd2,
    REG_KAPPA_TWO      = 2'd3
  } cfg_reg_t;

  typedef enum logic {
    OP_WRITE_FREQ = 1'b0,
    OP_QUERY_PAIR = 1'b1
  } req_op_t;

  // anything above 1.0 counts as exactly 1.0
  function automatic logic [FREQ_W-1:0] clamp_one(input logic [FREQ_W-1:0] v);
    return v[FREQ_W-1] ? ONE_Q : v;
  endfunction

endpackage

@@ rtl/gpp_req_if.sv @@
// request channel: frequency writes and genotype pair queries
interface gpp_req_if;
  logic                          valid;
  logic                          ready;
  logic                          op;
  logic [gpp_pkg::IDX_W-1:0]     write_index;
  logic [gpp_pkg::FREQ_W-1:0]    write_freq;
  logic [gpp_pkg::IDX_W-1:0]     first_allele_a;
  logic [gpp_pkg::IDX_W-1:0]     first_allele_b;
  logic [gpp_pkg::IDX_W-1:0]     second_allele_c;
  logic [gpp_pkg::IDX_W-1:0]     second_allele_d;

  modport source (
    output valid, op, write_index, write_freq,
    output first_allele_a, first_allele_b, second_allele_c, second_allele_d,
    input  ready
  );
  modport sink (
    input  valid, op, write_index, write_freq,
    input  first_allele_a, first_allele_b, second_allele_c, second_allele_d,
    output ready
  );
endinterface

@@ rtl/gpp_rsp_if.sv @@
// response channel: pair probability and bad allele flag
interface gpp_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [gpp_pkg::OUT_W-1:0]  pair_probability;
  logic                       bad_index;

  modport source (output valid, pair_probability, bad_index, input ready);
  modport sink   (input valid, pair_probability, bad_index, output ready);
endinterface

@@ rtl/genotype_pair_probability_top.sv @@
// genotype pair probability pipeline: frequency table, kinship weighting, rounding
//
// usage: frequencies are loaded through req with op = 0 (write_index, write_freq);
// a write transaction produces no response. a query (op = 1) names genotypes
// a,b and c,d and yields one rsp transaction with the Q2.30 pair probability,
// or zero with bad_index set when an allele is not below alleles_in_use.
// kappas and the allele count come in through the cfg_* write port, while idle.
// a query runs through registered stages for table read, genotype terms, kappa
// products, wide products and two adder levels before rsp.valid rises.
// throughput: one transaction per cycle on req unless a held rsp stalls the pipe;
// the table is kept twice so all four allele frequencies are read at accept.
// each stage holds only when its successor is full and held, so a stalled rsp
// still lets req fill empty stages; nothing is dropped or repeated.
// reset (rst, synchronous) clears every stage valid bit and loads the register
// defaults; the frequency table keeps its contents and must be written before use.
module genotype_pair_probability_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write_en,
  input  logic [gpp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [gpp_pkg::CFG_DATA_W-1:0]   cfg_data,
  gpp_req_if.sink                          req,
  gpp_rsp_if.source                        rsp
);

  localparam int FW = gpp_pkg::FREQ_W;

  // configuration
  logic [gpp_pkg::COUNT_W-1:0] alleles_in_use;
  logic [FW-1:0]               kappa_none;
  logic [FW-1:0]               kappa_one;
  logic [FW-1:0]               kappa_two;

  always_ff @(posedge clk) begin
    if (rst) begin
      alleles_in_use <= gpp_pkg::COUNT_W'(gpp_pkg::MAX_ALLELES);
      kappa_none     <= gpp_pkg::ONE_Q;
      kappa_one      <= '0;
      kappa_two      <= '0;
    end else if (cfg_write_en) begin
      unique case (gpp_pkg::cfg_reg_t'(cfg_index))
        gpp_pkg::REG_ALLELES_IN_USE: alleles_in_use <= cfg_data[gpp_pkg::COUNT_W-1:0];
        gpp_pkg::REG_KAPPA_NONE:     kappa_none     <= cfg_data;
        gpp_pkg::REG_KAPPA_ONE:      kappa_one      <= cfg_data;
        gpp_pkg::REG_KAPPA_TWO:      kappa_two      <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [FW-1:0] k0, k1, k2;
  assign k0 = gpp_pkg::clamp_one(kappa_none);
  assign k1 = gpp_pkg::clamp_one(kappa_one);
  assign k2 = gpp_pkg::clamp_one(kappa_two);

  // stage enables, each stage moves when empty or when its successor moves
  logic v1, v2, v3, v4, v5, v6;
  logic en1, en2, en3, en4, en5, en6;
  assign en6 = !v6 || rsp.ready;
  assign en5 = !v5 || en6;
  assign en4 = !v4 || en5;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign req.ready = en1;

  logic accept, wr_en, query_en;
  assign accept   = req.valid && req.ready;
  assign wr_en    = accept && (req.op == gpp_pkg::OP_WRITE_FREQ);
  assign query_en = accept && (req.op == gpp_pkg::OP_QUERY_PAIR);

  // stage 1: table read, index checks and allele matches
  logic [FW-1:0] freq_mem_ab [gpp_pkg::MAX_ALLELES];
  logic [FW-1:0] freq_mem_cd [gpp_pkg::MAX_ALLELES];
  logic [FW-1:0] fa1, fb1, fc1, fd1;
  logic          bad1, ab1, cd1, ac1, ad1, bc1, bd1;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      freq_mem_ab[req.write_index] <= req.write_freq;
      freq_mem_cd[req.write_index] <= req.write_freq;
    end
    if (en1) begin
      fa1 <= freq_mem_ab[req.first_allele_a];
      fb1 <= freq_mem_ab[req.first_allele_b];
      fc1 <= freq_mem_cd[req.second_allele_c];
      fd1 <= freq_mem_cd[req.second_allele_d];
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      bad1 <= (gpp_pkg::COUNT_W'(req.first_allele_a)  >= alleles_in_use) ||
              (gpp_pkg::COUNT_W'(req.first_allele_b)  >= alleles_in_use) ||
              (gpp_pkg::COUNT_W'(req.second_allele_c) >= alleles_in_use) ||
              (gpp_pkg::COUNT_W'(req.second_allele_d) >= alleles_in_use);
      ab1 <= req.first_allele_a == req.first_allele_b;
      cd1 <= req.second_allele_c == req.second_allele_d;
      ac1 <= req.first_allele_a == req.second_allele_c;
      ad1 <= req.first_allele_a == req.second_allele_d;
      bc1 <= req.first_allele_b == req.second_allele_c;
      bd1 <= req.first_allele_b == req.second_allele_d;
    end
  end

  // stage 2: genotype probabilities and transmission term
  logic [FW-1:0]                   fa, fb, fc, fd;
  logic [gpp_pkg::G_W-1:0]         g1_prod, g2_prod;
  logic [gpp_pkg::TRANS_W-1:0]     t2_comb;
  logic                            same_comb;

  assign fa = gpp_pkg::clamp_one(fa1);
  assign fb = gpp_pkg::clamp_one(fb1);
  assign fc = gpp_pkg::clamp_one(fc1);
  assign fd = gpp_pkg::clamp_one(fd1);
  assign g1_prod   = gpp_pkg::G_W'(fa) * gpp_pkg::G_W'(fb);
  assign g2_prod   = gpp_pkg::G_W'(fc) * gpp_pkg::G_W'(fd);
  assign same_comb = (ac1 && bd1) || (ad1 && bc1);

  always_comb begin
    t2_comb = '0;
    if (ab1) begin
      if (cd1)      t2_comb = ac1 ? {fa, 1'b0} : '0;
      else if (ac1) t2_comb = {fd, 1'b0};
      else if (ad1) t2_comb = {fc, 1'b0};
    end else if (cd1) begin
      if (ac1)      t2_comb = gpp_pkg::TRANS_W'(fa);
      else if (bc1) t2_comb = gpp_pkg::TRANS_W'(fb);
    end else if (same_comb) begin
      t2_comb = gpp_pkg::TRANS_W'(fa) + gpp_pkg::TRANS_W'(fb);
    end else if (ac1 || bc1) begin
      t2_comb = gpp_pkg::TRANS_W'(fd);
    end else if (ad1 || bd1) begin
      t2_comb = gpp_pkg::TRANS_W'(fc);
    end
  end

  logic [gpp_pkg::G_W-1:0]     g1_2, g2_2;
  logic [gpp_pkg::TRANS_W-1:0] t2_2;
  logic                        same2, bad2;

  always_ff @(posedge clk) begin
    if (en2) begin
      // heterozygotes count twice
      g1_2  <= ab1 ? g1_prod : g1_prod << 1;
      g2_2  <= cd1 ? g2_prod : g2_prod << 1;
      t2_2  <= t2_comb;
      same2 <= same_comb;
      bad2  <= bad1;
    end
  end

  // stage 3: kappa weighting of g1
  logic [gpp_pkg::KG_W-1:0]    p0_3, p1_3, p2_3;
  logic [gpp_pkg::G_W-1:0]     g2_3;
  logic [gpp_pkg::TRANS_W-1:0] t2_3;
  logic                        same3, bad3;

  always_ff @(posedge clk) begin
    if (en3) begin
      p0_3  <= gpp_pkg::KG_W'(k0) * gpp_pkg::KG_W'(g1_2);
      p1_3  <= gpp_pkg::KG_W'(k1) * gpp_pkg::KG_W'(g1_2);
      p2_3  <= gpp_pkg::KG_W'(k2) * gpp_pkg::KG_W'(g1_2);
      g2_3  <= g2_2;
      t2_3  <= t2_2;
      same3 <= same2;
      bad3  <= bad2;
    end
  end

  // stage 4: second factor, g2 split in two halves
  logic [gpp_pkg::PLO_W-1:0] plo4;
  logic [gpp_pkg::PHI_W-1:0] phi4;
  logic [gpp_pkg::PT_W-1:0]  pt4;
  logic [gpp_pkg::KG_W-1:0]  p2_4;
  logic                      same4, bad4;

  always_ff @(posedge clk) begin
    if (en4) begin
      plo4  <= gpp_pkg::PLO_W'(p0_3) * gpp_pkg::PLO_W'(g2_3[gpp_pkg::G2LO_W-1:0]);
      phi4  <= gpp_pkg::PHI_W'(p0_3) *
               gpp_pkg::PHI_W'(g2_3[gpp_pkg::G_W-1:gpp_pkg::G2LO_W]);
      pt4   <= gpp_pkg::PT_W'(p1_3) * gpp_pkg::PT_W'(t2_3);
      p2_4  <= p2_3;
      same4 <= same3;
      bad4  <= bad3;
    end
  end

  // stage 5: two partial sums at full fraction precision
  logic [gpp_pkg::ACC_W-1:0] sum_a5, sum_b5;
  logic                      bad5;

  always_ff @(posedge clk) begin
    if (en5) begin
      sum_a5 <= gpp_pkg::ACC_W'(plo4) + (gpp_pkg::ACC_W'(phi4) << gpp_pkg::G2LO_W);
      sum_b5 <= (gpp_pkg::ACC_W'(pt4) << gpp_pkg::TRANS_SHIFT) +
                (same4 ? gpp_pkg::ACC_W'(p2_4) << gpp_pkg::SAME_SHIFT : '0) +
                gpp_pkg::HALF;
      bad5   <= bad4;
    end
  end

  // stage 6: final add, round to nearest, saturate; this is the output register
  logic [gpp_pkg::ACC_W-1:0] total;
  logic [gpp_pkg::RES_W-1:0] scaled;
  assign total  = sum_a5 + sum_b5;
  assign scaled = total[gpp_pkg::ACC_W-1:gpp_pkg::ROUND_SHIFT];

  logic [gpp_pkg::OUT_W-1:0] prob6;
  logic                      bad6;

  always_ff @(posedge clk) begin
    if (en6) begin
      if (bad5) begin
        prob6 <= '0;
      end else if (scaled[gpp_pkg::RES_W-1:gpp_pkg::OUT_W] != '0) begin
        prob6 <= '1;
      end else begin
        prob6 <= scaled[gpp_pkg::OUT_W-1:0];
      end
      bad6 <= bad5;
    end
  end

  assign rsp.valid            = v6;
  assign rsp.pair_probability = prob6;
  assign rsp.bad_index        = bad6;

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else begin
      if (en1) v1 <= query_en;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en5) v5 <= v4;
      if (en6) v6 <= v5;
    end
  end

endmodule
